>>> hw/rtl/fccl_pkg.sv
// shared types, constants and helpers for the fat cluster chain locator
`default_nettype none
package fccl_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned HOPS_W = 23;
  localparam int unsigned WITHIN_W = 19;
  localparam int unsigned SECTOR_W = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_END = 3'd1;
  localparam logic [2:0] ST_BAD = 3'd2;
  localparam logic [2:0] ST_RESERVED = 3'd3;
  localparam logic [2:0] ST_FREE = 3'd4;
  localparam logic [2:0] ST_RANGE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;

  localparam logic [15:0] MARK_END0 = 16'hFFFF;
  localparam logic [15:0] MARK_END1 = 16'hFFF8;
  localparam logic [15:0] MARK_BAD = 16'hFFF7;
  localparam logic [15:0] MARK_RES0 = 16'hFFF0;
  localparam logic [15:0] MARK_RES1 = 16'hFFF5;
  localparam logic [15:0] MARK_RES2 = 16'hFFF6;
  localparam logic [15:0] MARK_FREE = 16'h0000;

  typedef struct packed {
    logic        mode;
    logic [11:0] entry_index;
    logic [15:0] entry_value;
    logic [15:0] start_cluster;
    logic [31:0] file_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_cluster;
    logic [35:0] byte_address;
    logic [19:0] bytes_left;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic read;
    logic fail_range;
    logic fail_entry;
    logic advance;
    logic sector;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic hops_zero;
    logic clus_ok;
    logic ent_ok;
  } dp_sts_t;

  function automatic logic [2:0] classify_entry(input logic [15:0] e);
    logic [2:0] st;
    st = ST_OK;
    if (e == MARK_END0 || e == MARK_END1) st = ST_END;
    else if (e == MARK_BAD) st = ST_BAD;
    else if (e == MARK_RES0 || e == MARK_RES1 || e == MARK_RES2) st = ST_RESERVED;
    else if (e == MARK_FREE) st = ST_FREE;
    return st;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fccl_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module fccl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/fccl_ctrl.sv
// controller state machine for table loads and chain walks
`default_nettype none
module fccl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_mode,
  input  wire fccl_pkg::dp_sts_t sts,
  output logic                   busy,
  output logic                   out_strobe,
  output fccl_pkg::dp_cmd_t      cmd
);
  import fccl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_EVAL   = 6'b000100,
    S_SECTOR = 6'b001000,
    S_ADDR   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_mode) begin
            cmd.capture = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            cmd.load = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_CHECK: begin
        if (!sts.clus_ok) begin
          cmd.fail_range = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.hops_zero) begin
          state_nxt = S_SECTOR;
        end else begin
          cmd.read = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.ent_ok) begin
          cmd.advance = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          cmd.fail_entry = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SECTOR: begin
        cmd.sector = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.finish = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/fccl_dp.sv
// datapath: config registers, table store, chain walk and address formation
`default_nettype none
module fccl_dp #(
  parameter int unsigned TABLE_ENTRIES = fccl_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [fccl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fccl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire fccl_pkg::in_item_t                  in_data,
  input  wire fccl_pkg::dp_cmd_t                   cmd,
  output fccl_pkg::dp_sts_t                        sts,
  output fccl_pkg::out_item_t                      res
);
  import fccl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [16:0] LIMIT = 17'(TABLE_ENTRIES);

  logic [3:0]  slog_cfg_r;
  logic [2:0]  csl_r;
  logic [15:0] data_start_r;

  logic [3:0]  slog;
  logic [4:0]  clog;
  logic [15:0] cluster_r;
  logic [HOPS_W-1:0] hops_r;
  logic [WITHIN_W-1:0] within_r;
  logic [SECTOR_W-1:0] sector_r;
  out_item_t res_r;

  logic        wr_en;
  logic [15:0] rdata;
  logic [2:0]  ent_class;
  logic [15:0] clus_m2;
  logic [35:0] addr;
  logic [19:0] left;
  logic [31:0] within_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slog_cfg_r <= 4'd9;
      csl_r <= 3'd2;
      data_start_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECTOR_LOG2:  slog_cfg_r <= cfg_wdata[3:0];
        CFG_CLUSTER_LOG2: csl_r <= cfg_wdata[2:0];
        CFG_DATA_START:   data_start_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slog_cfg_r < 4'd9) slog = 4'd9;
    else if (slog_cfg_r > 4'd12) slog = 4'd12;
    else slog = slog_cfg_r;
  end

  assign clog = 5'(slog) + 5'(csl_r);
  assign within_mask = (32'd1 << clog) - 32'd1;

  assign wr_en = cmd.load && (17'(in_data.entry_index) < LIMIT);

  fccl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(in_data.entry_index)),
    .wdata(in_data.entry_value),
    .re   (cmd.read),
    .raddr(AW'(cluster_r)),
    .rdata(rdata)
  );

  assign ent_class = classify_entry(rdata);
  assign sts.hops_zero = (hops_r == '0);
  assign sts.clus_ok = (cluster_r >= 16'd2) && (17'(cluster_r) < LIMIT);
  assign sts.ent_ok = (ent_class == ST_OK);

  assign clus_m2 = cluster_r - 16'd2;
  assign addr = (36'(sector_r) << slog) + 36'(within_r);
  assign left = (20'd1 << clog) - 20'(within_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cluster_r <= in_data.start_cluster;
      hops_r <= HOPS_W'(in_data.file_offset >> clog);
      within_r <= WITHIN_W'(in_data.file_offset & within_mask);
    end else if (cmd.advance) begin
      cluster_r <= rdata;
      hops_r <= hops_r - HOPS_W'(1);
    end
    if (cmd.sector) begin
      sector_r <= SECTOR_W'(data_start_r) + (SECTOR_W'(clus_m2) << csl_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= '{status: ((17'(in_data.entry_index) < LIMIT) ? ST_OK : ST_RANGE),
                 found_cluster: 16'd0, byte_address: 36'd0, bytes_left: 20'd0};
    end else if (cmd.fail_range) begin
      res_r <= '{status: ST_RANGE, found_cluster: 16'd0, byte_address: 36'd0,
                 bytes_left: 20'd0};
    end else if (cmd.fail_entry) begin
      res_r <= '{status: ent_class, found_cluster: 16'd0, byte_address: 36'd0,
                 bytes_left: 20'd0};
    end else if (cmd.finish) begin
      res_r.status <= ST_OK;
      res_r.found_cluster <= cluster_r;
      res_r.byte_address <= addr;
      res_r.bytes_left <= left;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

>>> hw/rtl/fat_cluster_chain_locator_unit.sv
// top level of the fat16 cluster chain locator
// load item: result strobed in the cycle right after the item is accepted
// locate item: a walk that runs to the end checks the cluster, takes each hop, then forms the sector and the address,
// hops = offset >> log2 cluster bytes; each hop reads the table and then classifies the entry
// one item at a time: busy drops the cycle after the strobe, and no new item is accepted while busy
// synchronous active-low reset returns control state and config registers to defaults; table contents persist
`default_nettype none
module fat_cluster_chain_locator_unit #(
  parameter int unsigned TABLE_ENTRIES = fccl_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire fccl_pkg::in_item_t              in_data,
  output logic                                 out_strobe,
  output fccl_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [fccl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fccl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fccl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fccl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_data.mode),
    .sts       (sts),
    .busy      (busy),
    .out_strobe(out_strobe),
    .cmd       (cmd)
  );

  fccl_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .res      (out_data)
  );

endmodule
`default_nettype wire
